// ----- hw/rtl/vang_pkg.sv -----
// Package for the 3D vector angle block: payload structs, datapath widths,
// the CORDIC arctangent table and fixed constants. No dependencies.
`default_nettype none

package vang_pkg;

  // Component width of the input vectors and fraction bits of the angle.
  localparam int unsigned COMPONENT_BITS  = 16;
  localparam int unsigned ANGLE_FRAC_BITS = 14;
  localparam int unsigned ANGLE_BITS      = ANGLE_FRAC_BITS + 2;

  // Cross and dot magnitudes are scaled below 2^SCALE_BITS.
  localparam int unsigned SCALE_BITS   = 30;
  // Square root operand width and the number of root cells.
  localparam int unsigned SQRT_BITS    = 64;
  localparam int unsigned SQRT_STEPS   = 32;
  // CORDIC vectoring: cells, x/y width and angle accumulator width.
  localparam int unsigned CORDIC_STEPS = 32;
  localparam int unsigned CORDIC_BITS  = 36;
  localparam int unsigned TURN_BITS    = 36;

  // 2*pi in Q29, applied to an angle in units of 2^-32 turn.
  localparam logic [31:0] TWO_PI_Q29   = 32'd3373259426;
  localparam logic [63:0] ANGLE_ROUND  = 64'd1 << (60 - ANGLE_FRAC_BITS);
  localparam int unsigned ANGLE_SHIFT  = 61 - ANGLE_FRAC_BITS;
  // Largest angle code, pi.
  localparam logic [ANGLE_BITS-1:0] ANGLE_MAX =
      ANGLE_BITS'(((64'd1 << 31) * 64'(TWO_PI_Q29) + ANGLE_ROUND) >> ANGLE_SHIFT);

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] a_x;
    logic signed [COMPONENT_BITS-1:0] a_y;
    logic signed [COMPONENT_BITS-1:0] a_z;
    logic signed [COMPONENT_BITS-1:0] b_x;
    logic signed [COMPONENT_BITS-1:0] b_y;
    logic signed [COMPONENT_BITS-1:0] b_z;
  } in_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] angle_rad;
    logic                  zero_length;
  } out_t;

  // Flags that ride along with an item through the cells.
  typedef struct packed {
    logic zero;  // either vector is all zero
    logic neg;   // dot product is negative
  } side_t;

  // Arctangent of 2^-i in units of 2^-32 turn, rounded to nearest.
  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;  1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;  3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;  9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6;  13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;  15: v = 32'h0000517D;
      16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30;  19: v = 32'h00000518;
      20: v = 32'h0000028C;  21: v = 32'h00000146;
      22: v = 32'h000000A3;  23: v = 32'h00000051;
      24: v = 32'h00000029;  25: v = 32'h00000014;
      26: v = 32'h0000000A;  27: v = 32'h00000005;
      28: v = 32'h00000003;  29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/vang_front.sv -----
// Front pipeline: products, cross and dot sums, scaling and the sum of squares.
// Depends on vang_pkg.
`default_nettype none

module vang_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                valid_i,
  output logic                                     ready_o,
  input  wire vang_pkg::in_t                       data_i,
  output logic                                     valid_o,
  input  wire logic                                ready_i,
  output logic [vang_pkg::SQRT_BITS-1:0]           n_o,
  output logic [vang_pkg::SCALE_BITS-1:0]          x_o,
  output vang_pkg::side_t                          side_o
);

  localparam int unsigned CB  = vang_pkg::COMPONENT_BITS;
  localparam int unsigned PW  = 2 * CB;
  localparam int unsigned MW  = PW + 2;
  localparam int unsigned SW  = $clog2(MW + 1);
  localparam int unsigned SB  = vang_pkg::SCALE_BITS;
  localparam int unsigned NB  = vang_pkg::SQRT_BITS;
  localparam int unsigned NST = 6;

  logic [NST-1:0] v_q;
  logic [NST-1:0] rdy;

  always_comb begin
    rdy[NST-1] = !v_q[NST-1] || ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 1: the nine products.
  logic signed [PW-1:0] p_aybz_q, p_azby_q, p_azbx_q, p_axbz_q, p_axby_q, p_aybx_q;
  logic signed [PW-1:0] p_axbx_q, p_ayby_q, p_azbz_q;
  vang_pkg::side_t      s1_q;
  logic                 zero_in;

  assign zero_in = (data_i.a_x == '0 && data_i.a_y == '0 && data_i.a_z == '0) ||
                   (data_i.b_x == '0 && data_i.b_y == '0 && data_i.b_z == '0);

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      p_aybz_q <= data_i.a_y * data_i.b_z;
      p_azby_q <= data_i.a_z * data_i.b_y;
      p_azbx_q <= data_i.a_z * data_i.b_x;
      p_axbz_q <= data_i.a_x * data_i.b_z;
      p_axby_q <= data_i.a_x * data_i.b_y;
      p_aybx_q <= data_i.a_y * data_i.b_x;
      p_axbx_q <= data_i.a_x * data_i.b_x;
      p_ayby_q <= data_i.a_y * data_i.b_y;
      p_azbz_q <= data_i.a_z * data_i.b_z;
      s1_q     <= '{zero: zero_in, neg: 1'b0};
    end
  end

  // Stage 2: cross components and the dot product, exact.
  logic signed [MW-1:0] cx_q, cy_q, cz_q, d_q;
  vang_pkg::side_t      s2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      cx_q <= MW'(p_aybz_q) - MW'(p_azby_q);
      cy_q <= MW'(p_azbx_q) - MW'(p_axbz_q);
      cz_q <= MW'(p_axby_q) - MW'(p_aybx_q);
      d_q  <= MW'(p_axbx_q) + MW'(p_ayby_q) + MW'(p_azbz_q);
      s2_q <= s1_q;
    end
  end

  // Stage 3: magnitudes and the scaling shift.
  logic [MW-1:0] m0, m1, m2, m3, orv;
  logic [SW-1:0] blen, shamt;
  logic [MW-1:0] m0_q, m1_q, m2_q, m3_q;
  logic [SW-1:0] sh_q;
  vang_pkg::side_t s3_q;

  always_comb begin
    m0   = cx_q[MW-1] ? MW'(-cx_q) : MW'(cx_q);
    m1   = cy_q[MW-1] ? MW'(-cy_q) : MW'(cy_q);
    m2   = cz_q[MW-1] ? MW'(-cz_q) : MW'(cz_q);
    m3   = d_q[MW-1]  ? MW'(-d_q)  : MW'(d_q);
    // The bit length of the OR equals that of the largest magnitude.
    orv  = m0 | m1 | m2 | m3;
    blen = '0;
    for (int i = 0; i < MW; i++) begin
      if (orv[i]) blen = SW'(i + 1);
    end
    shamt = (blen > SW'(SB)) ? blen - SW'(SB) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      m0_q <= m0;
      m1_q <= m1;
      m2_q <= m2;
      m3_q <= m3;
      sh_q <= shamt;
      s3_q <= '{zero: s2_q.zero, neg: d_q[MW-1]};
    end
  end

  // Stage 4: scale all four magnitudes by the same shift.
  logic [SB-1:0] q0_q, q1_q, q2_q, q3_q;
  vang_pkg::side_t s4_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      q0_q <= SB'(m0_q >> sh_q);
      q1_q <= SB'(m1_q >> sh_q);
      q2_q <= SB'(m2_q >> sh_q);
      q3_q <= SB'(m3_q >> sh_q);
      s4_q <= s3_q;
    end
  end

  // Stage 5: squares of the scaled cross magnitudes.
  logic [2*SB-1:0] sq0_q, sq1_q, sq2_q;
  logic [SB-1:0]   x5_q;
  vang_pkg::side_t s5_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      sq0_q <= q0_q * q0_q;
      sq1_q <= q1_q * q1_q;
      sq2_q <= q2_q * q2_q;
      x5_q  <= q3_q;
      s5_q  <= s4_q;
    end
  end

  // Stage 6: squared length of the cross product.
  logic [NB-1:0]   n_q;
  logic [SB-1:0]   x6_q;
  vang_pkg::side_t s6_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      n_q  <= NB'(sq0_q) + NB'(sq1_q) + NB'(sq2_q);
      x6_q <= x5_q;
      s6_q <= s5_q;
    end
  end

  assign n_o    = n_q;
  assign x_o    = x6_q;
  assign side_o = s6_q;

endmodule

`default_nettype wire

// ----- hw/rtl/vang_sqrt_cell.sv -----
// One cell of the square root row: one result bit per cell.
// Depends on vang_pkg.
`default_nettype none

module vang_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                valid_i,
  output logic                                     ready_o,
  input  wire logic [vang_pkg::SQRT_BITS-1:0]      n_i,
  input  wire logic [vang_pkg::SQRT_BITS-1:0]      r_i,
  input  wire logic [vang_pkg::SCALE_BITS-1:0]     x_i,
  input  wire vang_pkg::side_t                     side_i,
  output logic                                     valid_o,
  input  wire logic                                ready_i,
  output logic [vang_pkg::SQRT_BITS-1:0]           n_o,
  output logic [vang_pkg::SQRT_BITS-1:0]           r_o,
  output logic [vang_pkg::SCALE_BITS-1:0]          x_o,
  output vang_pkg::side_t                          side_o
);

  localparam int unsigned NB     = vang_pkg::SQRT_BITS;
  localparam int unsigned BITPOS = NB - 2 - 2 * STEP;
  localparam logic [NB-1:0] BIT  = NB'(1) << BITPOS;

  logic          v_q;
  logic [NB-1:0] trial, n_q, r_q;
  logic [vang_pkg::SCALE_BITS-1:0] x_q;
  vang_pkg::side_t side_q;

  assign ready_o = !v_q || ready_i;
  assign trial   = r_i + BIT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      if (n_i >= trial) begin
        n_q <= n_i - trial;
        r_q <= (r_i >> 1) + BIT;
      end else begin
        n_q <= n_i;
        r_q <= r_i >> 1;
      end
      x_q    <= x_i;
      side_q <= side_i;
    end
  end

  assign valid_o = v_q;
  assign n_o     = n_q;
  assign r_o     = r_q;
  assign x_o     = x_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

// ----- hw/rtl/vang_cordic_cell.sv -----
// One CORDIC vectoring cell: at most one micro-rotation by atan(2^-STEP), none when y is zero.
// Depends on vang_pkg.
`default_nettype none

module vang_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   valid_i,
  output logic                                        ready_o,
  input  wire logic signed [vang_pkg::CORDIC_BITS-1:0] x_i,
  input  wire logic signed [vang_pkg::CORDIC_BITS-1:0] y_i,
  input  wire logic signed [vang_pkg::TURN_BITS-1:0]   z_i,
  input  wire vang_pkg::side_t                        side_i,
  output logic                                        valid_o,
  input  wire logic                                   ready_i,
  output logic signed [vang_pkg::CORDIC_BITS-1:0]     x_o,
  output logic signed [vang_pkg::CORDIC_BITS-1:0]     y_o,
  output logic signed [vang_pkg::TURN_BITS-1:0]       z_o,
  output vang_pkg::side_t                             side_o
);

  localparam int unsigned CW = vang_pkg::CORDIC_BITS;
  localparam int unsigned ZW = vang_pkg::TURN_BITS;
  localparam logic signed [ZW-1:0] ATAN = ZW'(vang_pkg::atan_turn(STEP));

  logic                 v_q;
  logic signed [CW-1:0] dx, dy, x_q, y_q;
  logic signed [ZW-1:0] z_q;
  vang_pkg::side_t      side_q;

  assign ready_o = !v_q || ready_i;
  // Arithmetic shifts round toward minus infinity.
  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      if (y_i == '0) begin
        x_q <= x_i;
        y_q <= y_i;
        z_q <= z_i;
      end else if (!y_i[CW-1]) begin
        x_q <= x_i + dx;
        y_q <= y_i - dy;
        z_q <= z_i + ATAN;
      end else begin
        x_q <= x_i - dx;
        y_q <= y_i + dy;
        z_q <= z_i - ATAN;
      end
      side_q <= side_i;
    end
  end

  assign valid_o = v_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

// ----- hw/rtl/vector_angle_3d.sv -----
// Top level of the 3D vector angle block: front pipeline, square root row,
// CORDIC row and output stages. Depends on vang_pkg, vang_front and the cells.
`default_nettype none

// The block takes one pair of 3D vectors per cycle and returns the angle between
// them in radians as unsigned Q2.14, rounded to nearest, from 0 to pi. It forms
// the cross and dot products exactly, scales them below 2^30, takes the length of
// the cross product with a row of 32 square root cells (one result bit each) and
// turns (dot, |cross|) into an angle with a row of 32 CORDIC vectoring cells. An
// item passes from input transfer to output through 6 front stages, 32 root
// cells, one rounding stage, 32 CORDIC cells, then fold, scale multiply and the
// output register. Every stage holds its own valid bit and moves whenever the
// stage after it is empty or moving, so a new input transfer is taken every
// cycle while the pipeline has any free slot, also while a finished result waits
// in the output register. If either vector is all zero, zero_length is set and
// the angle is 0. There is no configuration and no state kept between items.

module vector_angle_3d (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire vang_pkg::in_t  in_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output vang_pkg::out_t      out_o
);

  localparam int unsigned NB  = vang_pkg::SQRT_BITS;
  localparam int unsigned SB  = vang_pkg::SCALE_BITS;
  localparam int unsigned CW  = vang_pkg::CORDIC_BITS;
  localparam int unsigned ZW  = vang_pkg::TURN_BITS;
  localparam int unsigned AW  = vang_pkg::ANGLE_BITS;
  localparam int unsigned NSQ = vang_pkg::SQRT_STEPS;
  localparam int unsigned NCO = vang_pkg::CORDIC_STEPS;

  localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'd1 << 30);
  localparam logic [31:0]          HALF_TURN    = 32'd1 << 31;

  // Square root row links; index k feeds cell k, index NSQ leaves the row.
  logic                 sq_v   [NSQ+1];
  logic                 sq_rdy [NSQ+1];
  logic [NB-1:0]        sq_n   [NSQ+1];
  logic [NB-1:0]        sq_r   [NSQ+1];
  logic [SB-1:0]        sq_x   [NSQ+1];
  vang_pkg::side_t      sq_s   [NSQ+1];

  // CORDIC row links.
  logic                 co_v   [NCO+1];
  logic                 co_rdy [NCO+1];
  logic signed [CW-1:0] co_x   [NCO+1];
  logic signed [CW-1:0] co_y   [NCO+1];
  logic signed [ZW-1:0] co_z   [NCO+1];
  vang_pkg::side_t      co_s   [NCO+1];

  vang_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_i),
    .valid_o (sq_v[0]),
    .ready_i (sq_rdy[0]),
    .n_o     (sq_n[0]),
    .x_o     (sq_x[0]),
    .side_o  (sq_s[0])
  );

  assign sq_r[0] = '0;

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    vang_sqrt_cell #(.STEP(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[k]),
      .ready_o (sq_rdy[k]),
      .n_i     (sq_n[k]),
      .r_i     (sq_r[k]),
      .x_i     (sq_x[k]),
      .side_i  (sq_s[k]),
      .valid_o (sq_v[k+1]),
      .ready_i (sq_rdy[k+1]),
      .n_o     (sq_n[k+1]),
      .r_o     (sq_r[k+1]),
      .x_o     (sq_x[k+1]),
      .side_o  (sq_s[k+1])
    );
  end

  // Output-side stage control: rounding, fold, multiply and output register.
  logic rnd_v_q, fold_v_q, mul_v_q, out_v_q;
  logic rdy_rnd, rdy_fold, rdy_mul, rdy_out;

  assign rdy_out      = !out_v_q || out_ready_i;
  assign rdy_mul      = !mul_v_q || rdy_out;
  assign rdy_fold     = !fold_v_q || rdy_mul;
  assign co_rdy[NCO]  = rdy_fold;
  assign rdy_rnd      = !rnd_v_q || co_rdy[0];
  assign sq_rdy[NSQ]  = rdy_rnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_v_q  <= 1'b0;
      fold_v_q <= 1'b0;
      mul_v_q  <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (rdy_rnd)  rnd_v_q  <= sq_v[NSQ];
      if (rdy_fold) fold_v_q <= co_v[NCO];
      if (rdy_mul)  mul_v_q  <= fold_v_q;
      if (rdy_out)  out_v_q  <= mul_v_q;
    end
  end

  // Rounding: the root is rounded up when the remainder exceeds it.
  logic signed [CW-1:0] rx_q, ry_q;
  vang_pkg::side_t      rs_q;

  always_ff @(posedge clk_i) begin
    if (rdy_rnd) begin
      rx_q <= CW'(sq_x[NSQ]);
      ry_q <= CW'(sq_r[NSQ]) + CW'(sq_n[NSQ] > sq_r[NSQ]);
      rs_q <= sq_s[NSQ];
    end
  end

  assign co_v[0] = rnd_v_q;
  assign co_x[0] = rx_q;
  assign co_y[0] = ry_q;
  assign co_z[0] = '0;
  assign co_s[0] = rs_q;

  for (genvar k = 0; k < NCO; k++) begin : g_cordic
    vang_cordic_cell #(.STEP(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (co_v[k]),
      .ready_o (co_rdy[k]),
      .x_i     (co_x[k]),
      .y_i     (co_y[k]),
      .z_i     (co_z[k]),
      .side_i  (co_s[k]),
      .valid_o (co_v[k+1]),
      .ready_i (co_rdy[k+1]),
      .x_o     (co_x[k+1]),
      .y_o     (co_y[k+1]),
      .z_o     (co_z[k+1]),
      .side_o  (co_s[k+1])
    );
  end

  // Fold: clamp to between zero and a quarter turn, mirror for a negative dot product.
  logic signed [ZW-1:0] z_end;
  logic [31:0]          z_clamp;
  logic [31:0]          zf_q;
  vang_pkg::side_t      fs_q;

  assign z_end = co_z[NCO];

  always_comb begin
    if (z_end[ZW-1]) begin
      z_clamp = '0;
    end else if (z_end > QUARTER_TURN) begin
      z_clamp = 32'(QUARTER_TURN);
    end else begin
      z_clamp = 32'(z_end);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_fold) begin
      zf_q <= co_s[NCO].neg ? HALF_TURN - z_clamp : z_clamp;
      fs_q <= co_s[NCO];
    end
  end

  // Turns to radians: a 32 by 32 bit multiply.
  logic [63:0]     prod_q;
  vang_pkg::side_t ms_q;

  always_ff @(posedge clk_i) begin
    if (rdy_mul) begin
      prod_q <= {32'd0, zf_q} * {32'd0, vang_pkg::TWO_PI_Q29};
      ms_q   <= fs_q;
    end
  end

  // Output register: round to the angle's fraction bits; angle 0 for a zero-length item.
  logic [63:0]    rounded;
  vang_pkg::out_t out_q;

  assign rounded = (prod_q + vang_pkg::ANGLE_ROUND) >> vang_pkg::ANGLE_SHIFT;

  always_ff @(posedge clk_i) begin
    if (rdy_out) begin
      out_q.angle_rad   <= ms_q.zero ? '0 : AW'(rounded);
      out_q.zero_length <= ms_q.zero;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/vang_checker.sv -----
// Port-level checks for the 3D vector angle block, bound to the top level.
// Depends on vang_pkg and vector_angle_3d.
`default_nettype none

module vang_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire vang_pkg::in_t  in_i,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire vang_pkg::out_t out_o
);

  // An input transfer that is refused stays offered with the same payload.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_i))
    else $error("input transfer withdrawn or changed while refused");

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("output transfer dropped or changed while stalled");

  // A zero-length result carries angle zero.
  a_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.zero_length |-> out_o.angle_rad == '0)
    else $error("zero_length result with nonzero angle");

  // The angle never exceeds pi.
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.angle_rad <= vang_pkg::ANGLE_MAX)
    else $error("angle above pi");

  // With the output free the pipeline never refuses an input transfer.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && in_valid_i |-> in_ready_o)
    else $error("input refused while output stage is empty");

endmodule

bind vector_angle_3d vang_checker u_checker (.*);

`default_nettype wire

// ----- bench/testbench.sv -----
// Testbench for vector_angle_3d: drives vector pairs, predicts angles and compares results.
// Depends on vang_pkg and the vector_angle_3d RTL only.
`timescale 1ns / 100ps

module testbench;

  localparam int CB = vang_pkg::COMPONENT_BITS;
  localparam int AB = vang_pkg::ANGLE_BITS;

  // Queue of predicted angles plus the comparison against what the block returns.
  class angle_scoreboard;
    vang_pkg::out_t pending_angles[$];
    int             mismatches;
    int             checked;

    function void note_input(vang_pkg::out_t predicted);
      pending_angles.push_back(predicted);
    endfunction

    function void check_result(vang_pkg::out_t got);
      vang_pkg::out_t want;
      if (pending_angles.size() == 0) begin
        $display("%0t: unexpected result angle=%0d zero=%0b", $time, got.angle_rad,
                 got.zero_length);
        mismatches++;
        return;
      end
      want = pending_angles.pop_front();
      checked++;
      if (got.angle_rad !== want.angle_rad) begin
        $display("%0t: angle_rad expected %0d actual %0d", $time, want.angle_rad,
                 got.angle_rad);
        mismatches++;
      end
      if (got.zero_length !== want.zero_length) begin
        $display("%0t: zero_length expected %0b actual %0b", $time, want.zero_length,
                 got.zero_length);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_angles.size();
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 200000;

  // Arctangent of 2^-i in units of 2^-32 of a full turn.
  localparam logic [31:0] ATAN_STEP [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  vang_pkg::in_t  in_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  vang_pkg::out_t out_o;

  angle_scoreboard scoreboard = new();

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned hold_off_cycles;
  int unsigned cycle_count;
  int unsigned sent_count;

  vector_angle_3d u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Rounded integer square root, bit by bit.
  function automatic longint unsigned root_rounded(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000000000000000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (n > r) r++;
    return r;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Angle between the two vectors: exact cross and dot, scaling below 2^30,
  // CORDIC vectoring on (|dot|, |cross|), then fold and scale to radians.
  function automatic vang_pkg::out_t predict_angle(vang_pkg::in_t v);
    vang_pkg::out_t  r;
    longint          ax, ay, az, bx, by, bz, cx, cy, cz, dot, xx, yy, dx, dy, z;
    longint unsigned mag[4];
    longint unsigned top, sum, q, prod;
    int              shift;
    ax = v.a_x; ay = v.a_y; az = v.a_z;
    bx = v.b_x; by = v.b_y; bz = v.b_z;
    r = '0;
    if ((ax == 0 && ay == 0 && az == 0) || (bx == 0 && by == 0 && bz == 0)) begin
      r.zero_length = 1'b1;
      return r;
    end
    cx = ay * bz - az * by;
    cy = az * bx - ax * bz;
    cz = ax * by - ay * bx;
    dot = ax * bx + ay * by + az * bz;
    mag[0] = abs64(cx); mag[1] = abs64(cy); mag[2] = abs64(cz); mag[3] = abs64(dot);
    top = 0;
    for (int i = 0; i < 4; i++) if (mag[i] > top) top = mag[i];
    shift = 0;
    while ((top >> shift) >= (64'd1 << 30)) shift++;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      q = mag[i] >> shift;
      sum += q * q;
    end
    xx = longint'(mag[3] >> shift);
    yy = longint'(root_rounded(sum));
    z = 0;
    for (int i = 0; i < 32; i++) begin
      // Arithmetic shifts of signed values round toward minus infinity.
      dx = yy >>> i;
      dy = xx >>> i;
      if (yy > 0) begin
        xx += dx; yy -= dy; z += longint'(ATAN_STEP[i]);
      end else if (yy < 0) begin
        xx -= dx; yy += dy; z -= longint'(ATAN_STEP[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > (64'sd1 <<< 30)) z = 64'sd1 <<< 30;
    if (dot < 0) z = (64'sd1 <<< 31) - z;
    prod = (longint'(z) * 64'd3373259426 + (64'd1 << (60 - vang_pkg::ANGLE_FRAC_BITS)))
           >> (61 - vang_pkg::ANGLE_FRAC_BITS);
    r.angle_rad = prod[AB-1:0];
    return r;
  endfunction

  function automatic vang_pkg::in_t make_pair(int ax, int ay, int az, int bx, int by,
                                              int bz);
    vang_pkg::in_t v;
    v.a_x = CB'(ax); v.a_y = CB'(ay); v.a_z = CB'(az);
    v.b_x = CB'(bx); v.b_y = CB'(by); v.b_z = CB'(bz);
    return v;
  endfunction

  function automatic int small_signed(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Random pair: mostly full-range vectors, plus parallel, antiparallel,
  // near-degenerate and zero-length cases.
  function automatic vang_pkg::in_t random_pair();
    vang_pkg::in_t v;
    int            k;
    v = vang_pkg::in_t'({$urandom, $urandom, $urandom});
    case ($urandom_range(9))
      0: begin
        if ($urandom_range(1)) begin
          v.a_x = 0; v.a_y = 0; v.a_z = 0;
        end else begin
          v.b_x = 0; v.b_y = 0; v.b_z = 0;
        end
      end
      1, 2: begin
        v.a_x = CB'(small_signed(1000)); v.a_y = CB'(small_signed(1000));
        v.a_z = CB'(small_signed(1000));
        k = small_signed(32);
        if (k == 0) k = 1;
        v.b_x = CB'(v.a_x * k + small_signed(1));
        v.b_y = CB'(v.a_y * k + small_signed(1));
        v.b_z = CB'(v.a_z * k);
      end
      3: begin
        v = make_pair(small_signed(3), small_signed(3), small_signed(3),
                      small_signed(3), small_signed(3), small_signed(3));
      end
      default: ;
    endcase
    return v;
  endfunction

  // Offer one item and hold it until the transfer happens. Valid is only
  // lowered while the sender idles, so back-to-back items keep it high.
  task automatic send_pair(vang_pkg::in_t v);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      in_i <= vang_pkg::in_t'({$urandom, $urandom, $urandom});
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    scoreboard.note_input(predict_angle(v));
    sent_count++;
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (scoreboard.outstanding() != 0) @(posedge clk_i);
  endtask

  // Receiver: checks each output transfer and then picks the next ready value.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) scoreboard.check_result(out_o);
    if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    vang_pkg::in_t directed[$];
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_cycles = 0;
    cycle_count = 0;
    sent_count = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero vectors, extremes, axis cases, parallel and opposite.
    directed.push_back(make_pair(0, 0, 0, 0, 0, 0));
    directed.push_back(make_pair(0, 0, 0, 5, -7, 9));
    directed.push_back(make_pair(1, 2, 3, 0, 0, 0));
    directed.push_back(make_pair(1, 0, 0, 1, 0, 0));
    directed.push_back(make_pair(1, 0, 0, -1, 0, 0));
    directed.push_back(make_pair(1, 0, 0, 0, 1, 0));
    directed.push_back(make_pair(0, 0, 1, 0, -1, 0));
    directed.push_back(make_pair(1, 1, 0, 1, 0, 0));
    directed.push_back(make_pair(-32768, -32768, -32768, -32768, -32768, -32768));
    directed.push_back(make_pair(32767, 32767, 32767, 32767, 32767, 32767));
    directed.push_back(make_pair(32767, 32767, 32767, -32768, -32768, -32768));
    directed.push_back(make_pair(-32768, 0, 0, 0, 32767, 0));
    directed.push_back(make_pair(32767, -32768, 32767, -32768, 32767, -32768));
    directed.push_back(make_pair(32767, 0, 0, 32767, 1, 0));
    directed.push_back(make_pair(-32768, 0, 0, 32767, 1, 0));
    directed.push_back(make_pair(1, 0, 0, -32768, 32767, 0));
    directed.push_back(make_pair(3, 4, 0, 4, -3, 0));
    directed.push_back(make_pair(-1, -1, -1, 1, 1, 1));
    directed.push_back(make_pair(32767, 32767, 0, -32768, 32767, 0));
    directed.push_back(make_pair(0, 0, -1, 0, 0, -32768));
    foreach (directed[i]) send_pair(directed[i]);
    wait_for_drain();

    // Random phases with different idling; the first also fills the pipeline
    // behind a long receiver hold-off while items keep arriving.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
        default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
      endcase
      for (int n = 0; n < 170; n++) begin
        if (phase == 0 && n == 10) hold_off_cycles = 250;
        send_pair(random_pair());
      end
      // Sender pauses here until every predicted angle has come back.
      wait_for_drain();
    end

    in_valid_i <= 1'b0;
    repeat (100) @(posedge clk_i);
    $display("Covered %0d vector pairs (%0d results checked): zero vectors, extremes,",
             sent_count, scoreboard.checked);
    $display("parallel and opposite pairs, full-range random, idle/stall and back-pressure.");
    if (scoreboard.mismatches == 0 && scoreboard.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
